// File: src/sti_pkg.sv
package sti_pkg;

    // Field widths and fixed-point formats
    localparam int ANGLE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 16;
    localparam int INT_BITS  = ANGLE_W - FRAC_BITS;

    localparam int DEG_TURN  = 360;
    localparam int QUAD      = 90;
    localparam int DEG_W     = $clog2(DEG_TURN + 1);
    localparam int R_W       = $clog2(QUAD);

    // Table words: signed, 30 fractional bits
    localparam int ROM_FRAC  = 30;
    localparam int ROM_W     = 32;

    // Degree reduction: bias the signed integer part by a multiple of a turn,
    // then divide by a turn through a scaled reciprocal
    localparam int     MOD_OFS  = DEG_TURN * ((2**(INT_BITS - 1) + DEG_TURN - 1) / DEG_TURN);
    localparam int     U_W      = $clog2(MOD_OFS + 2**(INT_BITS - 1));
    localparam int     RECIP_SH = U_W + 8;
    localparam longint RECIP    = (64'sd1 <<< RECIP_SH) / DEG_TURN;
    localparam int     RECIP_W  = $clog2(RECIP + 1);
    localparam int     Q_W      = U_W - 8;

    // Interpolation datapath
    localparam int DIFF_W = 27;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = ROM_W + FRAC_BITS + 2;
    localparam int SHIFT  = ROM_FRAC + FRAC_BITS - (OUT_BITS - 1);
    localparam int RES_W  = ACC_W - SHIFT;

    localparam logic [63:0] PI_Q40 = 64'h3243F6A8885;

    typedef logic signed [ROM_W-1:0] t_rom_word;
    typedef t_rom_word t_qrom [QUAD];

    typedef struct packed {
        logic                 valid;
        logic [DEG_W-1:0]     deg;
        logic [FRAC_BITS-1:0] frac;
    } t_deg_item;

    typedef struct packed {
        logic                 valid;
        logic [FRAC_BITS-1:0] frac;
        t_rom_word            s0;
        t_rom_word            s1;
        t_rom_word            c0;
        t_rom_word            c1;
    } t_pair_item;

    function automatic logic [63:0] term_mul(input logic [63:0] prev, input logic [63:0] x2);
        return (prev * x2 + (64'd1 << 29)) >> ROM_FRAC;
    endfunction

    // Taylor series over one quadrant, thirteen terms, each rounded
    function automatic t_rom_word taylor(input int r, input logic want_cos);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] acc;
        x  = ((64'(r) * PI_Q40) / 64'd180 + 64'd512) >> 10;
        x2 = (x * x + (64'd1 << 29)) >> ROM_FRAC;
        if (want_cos) begin
            t = 64'd1 << ROM_FRAC;
            acc = t;
            t = (term_mul(t, x2) + 64'd1)   / 64'd2;   acc = acc - t;
            t = (term_mul(t, x2) + 64'd6)   / 64'd12;  acc = acc + t;
            t = (term_mul(t, x2) + 64'd15)  / 64'd30;  acc = acc - t;
            t = (term_mul(t, x2) + 64'd28)  / 64'd56;  acc = acc + t;
            t = (term_mul(t, x2) + 64'd45)  / 64'd90;  acc = acc - t;
            t = (term_mul(t, x2) + 64'd66)  / 64'd132; acc = acc + t;
            t = (term_mul(t, x2) + 64'd91)  / 64'd182; acc = acc - t;
            t = (term_mul(t, x2) + 64'd120) / 64'd240; acc = acc + t;
            t = (term_mul(t, x2) + 64'd153) / 64'd306; acc = acc - t;
            t = (term_mul(t, x2) + 64'd190) / 64'd380; acc = acc + t;
            t = (term_mul(t, x2) + 64'd231) / 64'd462; acc = acc - t;
            t = (term_mul(t, x2) + 64'd276) / 64'd552; acc = acc + t;
        end else begin
            t = x;
            acc = t;
            t = (term_mul(t, x2) + 64'd3)   / 64'd6;   acc = acc - t;
            t = (term_mul(t, x2) + 64'd10)  / 64'd20;  acc = acc + t;
            t = (term_mul(t, x2) + 64'd21)  / 64'd42;  acc = acc - t;
            t = (term_mul(t, x2) + 64'd36)  / 64'd72;  acc = acc + t;
            t = (term_mul(t, x2) + 64'd55)  / 64'd110; acc = acc - t;
            t = (term_mul(t, x2) + 64'd78)  / 64'd156; acc = acc + t;
            t = (term_mul(t, x2) + 64'd105) / 64'd210; acc = acc - t;
            t = (term_mul(t, x2) + 64'd136) / 64'd272; acc = acc + t;
            t = (term_mul(t, x2) + 64'd171) / 64'd342; acc = acc - t;
            t = (term_mul(t, x2) + 64'd210) / 64'd420; acc = acc + t;
            t = (term_mul(t, x2) + 64'd253) / 64'd506; acc = acc - t;
            t = (term_mul(t, x2) + 64'd300) / 64'd600; acc = acc + t;
        end
        return $signed(acc[ROM_W-1:0]);
    endfunction

    function automatic t_qrom build_qrom(input logic want_cos);
        t_qrom rom;
        for (int r = 0; r < QUAD; r++) begin
            rom[r] = taylor(r, want_cos);
        end
        return rom;
    endfunction

    // First quadrant only; the rest of the turn follows by symmetry
    localparam t_qrom SIN_Q = build_qrom(1'b0);
    localparam t_qrom COS_Q = build_qrom(1'b1);

endpackage

// File: src/sti_reduce.sv
module sti_reduce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [sti_pkg::ANGLE_W-1:0]  i_angle,
    output sti_pkg::t_deg_item           o_item
);

    logic                                   r_v0;
    logic signed [sti_pkg::INT_BITS-1:0]    r_int;
    logic [sti_pkg::FRAC_BITS-1:0]          r_frac0;

    logic                                   r_v1;
    logic [sti_pkg::U_W-1:0]                r_u;
    logic [sti_pkg::Q_W-1:0]                r_q;
    logic [sti_pkg::FRAC_BITS-1:0]          r_frac1;

    sti_pkg::t_deg_item                     r_item;

    logic signed [sti_pkg::U_W:0]                   n_sum;
    logic [sti_pkg::U_W-1:0]                        n_u;
    logic [sti_pkg::U_W+sti_pkg::RECIP_W-1:0]       n_prod;
    logic [sti_pkg::Q_W-1:0]                        n_q;
    logic [sti_pkg::U_W-1:0]                        n_rem;
    logic [sti_pkg::DEG_W-1:0]                      n_deg;

    // Bias into a nonnegative range, then estimate the turn count
    always_comb begin
        n_sum  = (sti_pkg::U_W + 1)'(r_int) + (sti_pkg::U_W + 1)'(sti_pkg::MOD_OFS);
        n_u    = n_sum[sti_pkg::U_W-1:0];
        n_prod = (sti_pkg::U_W + sti_pkg::RECIP_W)'(n_u)
               * (sti_pkg::U_W + sti_pkg::RECIP_W)'(sti_pkg::RECIP);
        n_q    = n_prod[sti_pkg::RECIP_SH +: sti_pkg::Q_W];
    end

    // Estimate is exact or one short: fix with one compare and subtract
    always_comb begin
        n_rem = r_u - (sti_pkg::U_W'(r_q) * sti_pkg::U_W'(sti_pkg::DEG_TURN));
        if (n_rem >= sti_pkg::U_W'(sti_pkg::DEG_TURN)) begin
            n_deg = sti_pkg::DEG_W'(n_rem - sti_pkg::U_W'(sti_pkg::DEG_TURN));
        end else begin
            n_deg = sti_pkg::DEG_W'(n_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_item.valid <= 1'b0;
        end else begin
            r_v0         <= i_valid;
            r_v1         <= r_v0;
            r_item.valid <= r_v1;
        end
        r_int       <= $signed(i_angle[sti_pkg::ANGLE_W-1:sti_pkg::FRAC_BITS]);
        r_frac0     <= i_angle[sti_pkg::FRAC_BITS-1:0];
        r_u         <= n_u;
        r_q         <= n_q;
        r_frac1     <= r_frac0;
        r_item.deg  <= n_deg;
        r_item.frac <= r_frac1;
    end

    assign o_item = r_item;

endmodule

// File: src/sti_lookup.sv
module sti_lookup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sti_pkg::t_deg_item   i_item,
    output sti_pkg::t_pair_item  o_item
);

    typedef enum logic [1:0] {
        QD_0   = 2'd0,
        QD_90  = 2'd1,
        QD_180 = 2'd2,
        QD_270 = 2'd3
    } t_quad;

    sti_pkg::t_pair_item        r_item;
    logic [sti_pkg::DEG_W-1:0]  n_d1;

    // Full-turn table entry from the first-quadrant tables
    function automatic sti_pkg::t_rom_word pick(input logic [sti_pkg::DEG_W-1:0] d,
                                                input logic want_cos);
        t_quad                     q;
        logic [sti_pkg::DEG_W-1:0] r;
        sti_pkg::t_rom_word        s;
        sti_pkg::t_rom_word        c;
        sti_pkg::t_rom_word        res;
        if (d >= sti_pkg::DEG_W'(sti_pkg::DEG_TURN)) begin
            q = QD_0;
            r = '0;
        end else if (d >= sti_pkg::DEG_W'(3 * sti_pkg::QUAD)) begin
            q = QD_270;
            r = d - sti_pkg::DEG_W'(3 * sti_pkg::QUAD);
        end else if (d >= sti_pkg::DEG_W'(2 * sti_pkg::QUAD)) begin
            q = QD_180;
            r = d - sti_pkg::DEG_W'(2 * sti_pkg::QUAD);
        end else if (d >= sti_pkg::DEG_W'(sti_pkg::QUAD)) begin
            q = QD_90;
            r = d - sti_pkg::DEG_W'(sti_pkg::QUAD);
        end else begin
            q = QD_0;
            r = d;
        end
        s = sti_pkg::SIN_Q[r[sti_pkg::R_W-1:0]];
        c = sti_pkg::COS_Q[r[sti_pkg::R_W-1:0]];
        case (q)
            QD_0:    res = want_cos ? c  : s;
            QD_90:   res = want_cos ? -s : c;
            QD_180:  res = want_cos ? -c : -s;
            QD_270:  res = want_cos ? s  : -c;
            default: res = s;
        endcase
        return res;
    endfunction

    assign n_d1 = i_item.deg + sti_pkg::DEG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= i_item.valid;
        end
        r_item.frac <= i_item.frac;
        r_item.s0   <= pick(i_item.deg, 1'b0);
        r_item.s1   <= pick(n_d1, 1'b0);
        r_item.c0   <= pick(i_item.deg, 1'b1);
        r_item.c1   <= pick(n_d1, 1'b1);
    end

    assign o_item = r_item;

endmodule

// File: src/sti_interp.sv
module sti_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sti_pkg::t_pair_item                 i_item,
    output logic                                o_valid,
    output logic signed [sti_pkg::OUT_BITS-1:0] o_sine,
    output logic signed [sti_pkg::OUT_BITS-1:0] o_cosine
);

    localparam int LANES = 2;
    localparam logic signed [sti_pkg::RES_W-1:0] MAXV =
        sti_pkg::RES_W'((64'sd1 <<< (sti_pkg::OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [sti_pkg::RES_W-1:0] MINV =
        sti_pkg::RES_W'(-(64'sd1 <<< (sti_pkg::OUT_BITS - 1)));
    localparam logic signed [sti_pkg::ACC_W-1:0] RND =
        sti_pkg::ACC_W'(64'sd1 <<< (sti_pkg::SHIFT - 1));

    sti_pkg::t_rom_word                        y0_in [LANES];
    sti_pkg::t_rom_word                        y1_in [LANES];

    logic                                      r_va;
    logic [sti_pkg::FRAC_BITS-1:0]             r_fa;
    sti_pkg::t_rom_word                        r_y0a [LANES];
    logic signed [sti_pkg::DIFF_W-1:0]         r_diff [LANES];

    logic                                      r_vb;
    sti_pkg::t_rom_word                        r_y0b [LANES];
    logic signed [sti_pkg::PROD_W-1:0]         r_prod [LANES];

    logic                                      r_vo;
    logic signed [sti_pkg::OUT_BITS-1:0]       r_res [LANES];

    assign y0_in[0] = i_item.s0;
    assign y1_in[0] = i_item.s1;
    assign y0_in[1] = i_item.c0;
    assign y1_in[1] = i_item.c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_va <= i_item.valid;
            r_vb <= r_va;
            r_vo <= r_vb;
        end
        r_fa <= i_item.frac;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [sti_pkg::ROM_W:0]      n_diff_w;
        logic signed [sti_pkg::PROD_W-1:0]   n_prod;
        logic signed [sti_pkg::ACC_W-1:0]    n_acc;
        logic signed [sti_pkg::RES_W-1:0]    n_q;
        logic signed [sti_pkg::OUT_BITS-1:0] n_res;

        // Neighbor entries differ by at most one degree's worth of slope
        assign n_diff_w = (sti_pkg::ROM_W + 1)'(y1_in[l]) - (sti_pkg::ROM_W + 1)'(y0_in[l]);
        assign n_prod   = sti_pkg::PROD_W'(r_diff[l])
                        * sti_pkg::PROD_W'($signed({1'b0, r_fa}));

        // Floor of the scaled sum after adding half an LSB, saturated to the output range
        always_comb begin
            n_acc = (sti_pkg::ACC_W'(r_y0b[l]) <<< sti_pkg::FRAC_BITS)
                  + sti_pkg::ACC_W'(r_prod[l]) + RND;
            n_q   = n_acc[sti_pkg::ACC_W-1:sti_pkg::SHIFT];
            if (n_q > MAXV) begin
                n_res = MAXV[sti_pkg::OUT_BITS-1:0];
            end else if (n_q < MINV) begin
                n_res = MINV[sti_pkg::OUT_BITS-1:0];
            end else begin
                n_res = n_q[sti_pkg::OUT_BITS-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_y0a[l]  <= y0_in[l];
            r_diff[l] <= n_diff_w[sti_pkg::DIFF_W-1:0];
            r_y0b[l]  <= r_y0a[l];
            r_prod[l] <= n_prod;
            r_res[l]  <= n_res;
        end
    end

    assign o_valid  = r_vo;
    assign o_sine   = r_res[0];
    assign o_cosine = r_res[1];

endmodule

// File: src/sincos_table_interpolator_core.sv
// Channel   Direction  Handshake               Payload
// command   in         start, busy             i_angle   (s16.16 degrees)
// result    out        o_done (one-cycle)      o_sine, o_cosine (Q1.15)
//
// One angle per clock cycle; busy is high only while reset is held.
// o_done marks a result that has passed through three stages
// for the reduction modulo 360 (input, reciprocal multiply, compare and
// subtract), one for the quadrant table reads, three for the difference,
// the slope multiply, and rounding with saturation.
// Reset is synchronous and active low; it drops every item in flight.
// The receiver cannot stall, so the pipeline never holds.
module sincos_table_interpolator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sti_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_done,
    output logic signed [sti_pkg::OUT_BITS-1:0] o_sine,
    output logic signed [sti_pkg::OUT_BITS-1:0] o_cosine
);

    logic                 accept;
    sti_pkg::t_deg_item   deg_item;
    sti_pkg::t_pair_item  pair_item;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    sti_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_angle (i_angle),
        .o_item  (deg_item)
    );

    sti_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (deg_item),
        .o_item  (pair_item)
    );

    sti_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (pair_item),
        .o_valid  (o_done),
        .o_sine   (o_sine),
        .o_cosine (o_cosine)
    );

endmodule

// File: src/sti_checker.sv
module sti_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [sti_pkg::ANGLE_W-1:0]  i_angle,
    input logic                                o_done,
    input logic signed [sti_pkg::OUT_BITS-1:0] o_sine,
    input logic signed [sti_pkg::OUT_BITS-1:0] o_cosine
);

    // Every transfer yields exactly one result at fixed latency
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_done)
        else $error("result missing seven cycles after transfer");

    a_done_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 7))
        else $error("result without a matching transfer");

    a_zero_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_angle, 7) == 32'sh0000_0000))
        |-> ((o_sine == 16'sh0000) && (o_cosine == 16'sh7FFF)))
        else $error("wrong result at zero degrees");

    a_ninety_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_angle, 7) == 32'sh005A_0000))
        |-> ((o_sine == 16'sh7FFF) && (o_cosine == 16'sh0000)))
        else $error("wrong result at ninety degrees");

endmodule

bind sincos_table_interpolator_core sti_checker u_sti_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_angle  (i_angle),
    .o_done   (o_done),
    .o_sine   (o_sine),
    .o_cosine (o_cosine)
);
